// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescaper: result kinds, error
// codes, parser modes and the command that travels from the parser to the
// result stage.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // result kinds
  typedef enum logic [1:0] {
    K_BYTE = 2'd0,
    K_END  = 2'd1,
    K_ERR  = 2'd2
  } kind_t;

  // error codes
  typedef enum logic [2:0] {
    E_NONE     = 3'd0,
    E_NO_QUOTE = 3'd1,
    E_BAD_ESC  = 3'd2,
    E_BAD_HEX  = 3'd3,
    E_BAD_SUR  = 3'd4,
    E_BAD_UTF8 = 3'd5,
    E_CTRL     = 3'd6
  } err_t;

  // parser modes
  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_STR    = 3'd1,
    M_ESC    = 3'd2,
    M_HEX1   = 3'd3,
    M_SUR_BS = 3'd4,
    M_SUR_U  = 3'd5,
    M_HEX2   = 3'd6,
    M_UTF    = 3'd7
  } mode_t;

  // allowed range of the first continuation byte
  typedef enum logic [2:0] {
    C_FULL = 3'd0,
    C_E0   = 3'd1,
    C_ED   = 3'd2,
    C_F0   = 3'd3,
    C_F4   = 3'd4
  } cls_t;

  // depth of the command queue between parser and result stage
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_BITS = $clog2(QDEPTH);

  // all results caused by one input byte
  typedef struct packed {
    kind_t           kind;
    err_t            code;
    logic [1:0]      last_idx;   // number of results minus one
    logic [15:0]     len;
    logic [3:0][7:0] bytes;
  } cmd_t;

endpackage

// File: rtl/json_string_unescape_utf8_check_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_check_top
// JSON string unescaper with UTF-8 checking: parser, command queue and
// result stage.
// ----------------------------------------------------------------------------
// The block takes one byte of a quoted string per cycle while full is low and
// gives each byte's results (a decoded byte, one to four UTF-8 bytes of a \u
// escape or surrogate pair, an end-of-string result or an error) one per cycle
// while pop is high. The parser handles every input byte combinationally and
// writes its results as one entry into a four-entry queue; the result stage
// loads the head entry into a result register and emits its results in turn,
// and input stalls (full high) only once the queue is full. A result passes
// through the queue entry and then the result register before it appears.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_check_top #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic [2:0]  error_code,
  output logic [15:0] decoded_length,
  output logic        last
);

  logic          accept;
  logic          cmd_valid;
  jsu_pkg::cmd_t cmd;
  logic          q_empty, q_pop;
  jsu_pkg::cmd_t q_head;

  assign accept = push && !full;

  jsu_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && cmd_valid),
    .push_cmd (cmd),
    .full     (full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .kind           (kind),
    .error_code     (error_code),
    .decoded_length (decoded_length),
    .last           (last)
  );

endmodule

// File: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser: takes one string byte per transfer, runs the escape, hex and UTF-8
// state machine and hands the results of each byte to the queue as one cmd.
// ----------------------------------------------------------------------------
module jsu_front #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  output logic          cmd_valid,
  output jsu_pkg::cmd_t cmd
);

  typedef struct packed {
    logic [1:0]      n_m1;
    logic [3:0][7:0] bytes;
  } enc_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // hex digit value, with a valid flag in the top bit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // utf-8 encoding of a code point
  function automatic enc_t encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.n_m1 = 2'd0;
      e.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.n_m1 = 2'd1;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.n_m1 = 2'd2;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.n_m1 = 2'd3;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  jsu_pkg::mode_t         mode, mode_next;
  logic [1:0]             hex_cnt, hex_cnt_next;
  logic [11:0]            acc, acc_next;
  logic [9:0]             hs, hs_next;
  logic [1:0]             cont_left, cont_left_next;
  jsu_pkg::cls_t          cls, cls_next;
  logic [LENGTH_BITS-1:0] length, length_next;

  logic                   fail_en;
  jsu_pkg::err_t          fail_code;
  logic                   emit_bytes;
  logic                   emit_end;
  enc_t                   enc;
  logic [4:0]             hv;
  logic [15:0]            cp16;
  logic [20:0]            cp_pair;
  logic [7:0]             lo_lim, hi_lim;
  logic [LENGTH_BITS:0]   len_sum;
  logic [LENGTH_BITS+15:0] len_ext;
  logic [15:0]            len_rep;

  // saturated length as reported with the end result
  always_comb begin
    len_ext = {16'd0, length};
    if (len_ext > {{LENGTH_BITS{1'b0}}, 16'hFFFF}) len_rep = 16'hFFFF;
    else len_rep = len_ext[15:0];
  end

  // per-byte parse and classification
  always_comb begin
    mode_next      = mode;
    hex_cnt_next   = hex_cnt;
    acc_next       = acc;
    hs_next        = hs;
    cont_left_next = cont_left;
    cls_next       = cls;
    length_next    = length;
    fail_en        = 1'b0;
    fail_code      = jsu_pkg::E_NONE;
    emit_bytes     = 1'b0;
    emit_end       = 1'b0;
    enc            = '0;
    hv             = hex_value(data_byte);
    cp16           = {acc, hv[3:0]};
    cp_pair        = 21'({1'b0, hs, cp16[9:0]}) + 21'h10000;
    lo_lim         = 8'h80;
    hi_lim         = 8'hBF;
    unique case (cls)
      jsu_pkg::C_E0: lo_lim = 8'hA0;
      jsu_pkg::C_ED: hi_lim = 8'h9F;
      jsu_pkg::C_F0: lo_lim = 8'h90;
      jsu_pkg::C_F4: hi_lim = 8'h8F;
      default: ;
    endcase

    unique case (mode)
      jsu_pkg::M_STR: begin
        if (data_byte == 8'h22) begin
          emit_end  = 1'b1;
          mode_next = jsu_pkg::M_IDLE;
        end else if (data_byte == 8'h5C) begin
          mode_next = jsu_pkg::M_ESC;
        end else if (data_byte < 8'h20) begin
          fail_en   = 1'b1;
          fail_code = jsu_pkg::E_CTRL;
        end else if (data_byte < 8'h80) begin
          emit_bytes     = 1'b1;
          enc.bytes[0]   = data_byte;
        end else begin
          // raw utf-8 leader
          emit_bytes   = 1'b1;
          enc.bytes[0] = data_byte;
          mode_next    = jsu_pkg::M_UTF;
          cls_next     = jsu_pkg::C_FULL;
          if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
            cont_left_next = 2'd1;
          end else if (data_byte == 8'hE0) begin
            cont_left_next = 2'd2;
            cls_next       = jsu_pkg::C_E0;
          end else if (data_byte == 8'hED) begin
            cont_left_next = 2'd2;
            cls_next       = jsu_pkg::C_ED;
          end else if (data_byte >= 8'hE1 && data_byte <= 8'hEF) begin
            cont_left_next = 2'd2;
          end else if (data_byte == 8'hF0) begin
            cont_left_next = 2'd3;
            cls_next       = jsu_pkg::C_F0;
          end else if (data_byte == 8'hF4) begin
            cont_left_next = 2'd3;
            cls_next       = jsu_pkg::C_F4;
          end else if (data_byte >= 8'hF1 && data_byte <= 8'hF3) begin
            cont_left_next = 2'd3;
          end else begin
            emit_bytes = 1'b0;
            fail_en    = 1'b1;
            fail_code  = jsu_pkg::E_BAD_UTF8;
          end
        end
      end
      jsu_pkg::M_ESC: begin
        mode_next  = jsu_pkg::M_STR;
        emit_bytes = 1'b1;
        unique case (data_byte)
          8'h22:   enc.bytes[0] = 8'h22;
          8'h5C:   enc.bytes[0] = 8'h5C;
          8'h2F:   enc.bytes[0] = 8'h2F;
          8'h62:   enc.bytes[0] = 8'h08;
          8'h66:   enc.bytes[0] = 8'h0C;
          8'h6E:   enc.bytes[0] = 8'h0A;
          8'h72:   enc.bytes[0] = 8'h0D;
          8'h74:   enc.bytes[0] = 8'h09;
          8'h75: begin
            emit_bytes   = 1'b0;
            hex_cnt_next = 2'd0;
            acc_next     = 12'd0;
            mode_next    = jsu_pkg::M_HEX1;
          end
          default: begin
            emit_bytes = 1'b0;
            fail_en    = 1'b1;
            fail_code  = jsu_pkg::E_BAD_ESC;
          end
        endcase
      end
      jsu_pkg::M_HEX1, jsu_pkg::M_HEX2: begin
        if (!hv[4]) begin
          fail_en   = 1'b1;
          fail_code = jsu_pkg::E_BAD_HEX;
        end else if (hex_cnt != 2'd3) begin
          acc_next     = {acc[7:0], hv[3:0]};
          hex_cnt_next = hex_cnt + 2'd1;
        end else begin
          hex_cnt_next = 2'd0;
          acc_next     = 12'd0;
          if (mode == jsu_pkg::M_HEX1) begin
            if (cp16 >= 16'hD800 && cp16 <= 16'hDBFF) begin
              hs_next   = cp16[9:0];
              mode_next = jsu_pkg::M_SUR_BS;
            end else if (cp16 >= 16'hDC00 && cp16 <= 16'hDFFF) begin
              fail_en   = 1'b1;
              fail_code = jsu_pkg::E_BAD_SUR;
            end else begin
              emit_bytes = 1'b1;
              enc        = encode({5'd0, cp16});
              mode_next  = jsu_pkg::M_STR;
            end
          end else begin
            if (cp16 < 16'hDC00 || cp16 > 16'hDFFF) begin
              fail_en   = 1'b1;
              fail_code = jsu_pkg::E_BAD_SUR;
            end else begin
              emit_bytes = 1'b1;
              enc        = encode(cp_pair);
              hs_next    = 10'd0;
              mode_next  = jsu_pkg::M_STR;
            end
          end
        end
      end
      jsu_pkg::M_SUR_BS: begin
        if (data_byte == 8'h5C) begin
          mode_next = jsu_pkg::M_SUR_U;
        end else begin
          fail_en   = 1'b1;
          fail_code = jsu_pkg::E_BAD_SUR;
        end
      end
      jsu_pkg::M_SUR_U: begin
        if (data_byte == 8'h75) begin
          hex_cnt_next = 2'd0;
          acc_next     = 12'd0;
          mode_next    = jsu_pkg::M_HEX2;
        end else begin
          fail_en   = 1'b1;
          fail_code = jsu_pkg::E_BAD_SUR;
        end
      end
      jsu_pkg::M_UTF: begin
        if (data_byte < lo_lim || data_byte > hi_lim) begin
          fail_en   = 1'b1;
          fail_code = jsu_pkg::E_BAD_UTF8;
        end else begin
          emit_bytes     = 1'b1;
          enc.bytes[0]   = data_byte;
          cls_next       = jsu_pkg::C_FULL;
          cont_left_next = cont_left - 2'd1;
          if (cont_left == 2'd1) mode_next = jsu_pkg::M_STR;
        end
      end
      default: begin
        // idle: waiting for the opening quote
        if (data_byte == 8'h22) begin
          mode_next   = jsu_pkg::M_STR;
          length_next = '0;
        end else begin
          fail_en   = 1'b1;
          fail_code = jsu_pkg::E_NO_QUOTE;
        end
      end
    endcase

    // a failure or the closing quote clears the work registers
    if (fail_en || emit_end) begin
      mode_next      = jsu_pkg::M_IDLE;
      hex_cnt_next   = 2'd0;
      acc_next       = 12'd0;
      hs_next        = 10'd0;
      cont_left_next = 2'd0;
      cls_next       = jsu_pkg::C_FULL;
    end

    // saturating decoded-length count
    len_sum = {1'b0, length} + (LENGTH_BITS + 1)'(enc.n_m1) + 1'b1;
    if (emit_bytes) begin
      if (len_sum[LENGTH_BITS]) length_next = LEN_MAX;
      else length_next = len_sum[LENGTH_BITS-1:0];
    end

    // command for the queue
    cmd       = '0;
    cmd_valid = fail_en || emit_end || emit_bytes;
    priority if (fail_en) begin
      cmd.kind = jsu_pkg::K_ERR;
      cmd.code = fail_code;
    end else if (emit_end) begin
      cmd.kind = jsu_pkg::K_END;
      cmd.len  = len_rep;
    end else begin
      cmd.kind     = jsu_pkg::K_BYTE;
      cmd.last_idx = enc.n_m1;
      cmd.bytes    = enc.bytes;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= jsu_pkg::M_IDLE;
      hex_cnt   <= 2'd0;
      acc       <= 12'd0;
      hs        <= 10'd0;
      cont_left <= 2'd0;
      cls       <= jsu_pkg::C_FULL;
      length    <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_cnt   <= hex_cnt_next;
      acc       <= acc_next;
      hs        <= hs_next;
      cont_left <= cont_left_next;
      cls       <= cls_next;
      length    <= length_next;
    end
  end

endmodule

// File: rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short command queue between parser and result stage, so each side can
// stall on its own.
// ----------------------------------------------------------------------------
module jsu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output jsu_pkg::cmd_t head
);

  localparam int unsigned PB = jsu_pkg::QPTR_BITS;
  localparam logic [PB:0] DEPTH = (PB + 1)'(jsu_pkg::QDEPTH);

  jsu_pkg::cmd_t entry [jsu_pkg::QDEPTH];
  logic [PB-1:0] wr_ptr, rd_ptr;
  logic [PB:0]   count;
  logic          do_push, do_pop;

  assign full    = (count == DEPTH);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH)
    else $error("queue fill count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("parser pushed into full queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

// File: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Result stage: takes commands from the queue and presents their results one
// per transfer, marking the final result of each input byte.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  jsu_pkg::cmd_t q_head,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic [1:0]    kind,
  output logic [2:0]    error_code,
  output logic [15:0]   decoded_length,
  output logic          last
);

  jsu_pkg::cmd_t cur;
  logic          cur_valid;
  logic [1:0]    idx;
  logic          take, at_last;

  assign at_last = (idx == cur.last_idx);
  assign take    = pop && cur_valid;
  assign q_pop   = !q_empty && (!cur_valid || (take && at_last));

  // current command and result index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (take) begin
      if (at_last) cur_valid <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
  end

  // result ports
  assign empty          = !cur_valid;
  assign out_byte       = cur.bytes[idx];
  assign kind           = cur.kind;
  assign error_code     = cur.code;
  assign decoded_length = cur.len;
  assign last           = at_last;

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx <= cur.last_idx))
    else $error("result index past end of command");
  a_single: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && cur.kind != jsu_pkg::K_BYTE) |-> (cur.last_idx == 2'd0))
    else $error("end or error command with several results");
  a_held: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !pop) |=> (cur_valid && idx == $past(idx)))
    else $error("waiting result dropped");

endmodule

// File: verif/json_string_unescape_utf8_check_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_check_top_test
// Self-checking bench for the JSON string unescaper. A stimulus queue holds
// the raw string bytes. It is filled with a directed opening, one string of
// plain bytes sent nearly back to back, and then random strings that are mostly
// well formed with some faults. A driver offers the bytes with random gaps.
// Each accepted byte goes through an in-bench decoder that predicts its
// results. A monitor pops results with random stalls and one long hold, and
// checks every result field by field against the prediction.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_check_top_test;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_BYTES = 340;
  localparam int unsigned BRISK_STRING_BYTES = 60;
  localparam int unsigned HOLD_CYCLES = 300;

  localparam logic [7:0] QUOTE = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] LETTER_U = 8'h75;

  typedef struct packed {
    logic [7:0]     b;
    jsu_pkg::kind_t k;
    jsu_pkg::err_t  code;
    logic [15:0]    len;
    logic           fin;
  } result_t;

  typedef struct {
    logic [7:0] b;
    logic       brisk;
  } raw_byte_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [2:0]  error_code;
  logic [15:0] decoded_length;
  logic        last;

  // decoder state
  jsu_pkg::mode_t mode = jsu_pkg::M_IDLE;
  logic [1:0]     hex_cnt = '0;
  logic [15:0]    acc = '0;
  logic [9:0]     hi_bits = '0;
  logic [1:0]     cont_left = '0;
  jsu_pkg::cls_t  sb_class = jsu_pkg::C_FULL;
  logic [15:0]    str_len = '0;
  result_t        step_res [4];
  int             n_step;

  // stimulus and expected output stream
  raw_byte_t   raw_bytes_q [$];
  result_t     unescaped_q [$];
  logic        fill_brisk = 1'b0;

  // handshake bookkeeping
  raw_byte_t   sent;
  result_t     want;
  logic        brisk_mode = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          tx_calm = 0;
  int          rx_calm = 0;
  int unsigned n_accepted = 0;
  int unsigned n_seen = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned cycle_n = 0;
  int unsigned fail_count = 0;

  logic [7:0] esc_letters [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};

  // no-quote error, \u0000, U+10FFFF as a surrogate pair, then as raw bytes
  logic [7:0] opening_bytes [26] = '{
    8'hFF, QUOTE, 8'h7F,
    BSLASH, LETTER_U, 8'h30, 8'h30, 8'h30, 8'h30,
    BSLASH, LETTER_U, 8'h44, 8'h42, 8'h66, 8'h46,
    BSLASH, LETTER_U, 8'h64, 8'h46, 8'h46, 8'h66,
    8'hF4, 8'h8F, 8'hBF, 8'hBF, QUOTE
  };

  json_string_unescape_utf8_check_top DUT (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .kind           (kind),
    .error_code     (error_code),
    .decoded_length (decoded_length),
    .last           (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- decoder

  function automatic void add_result(logic [7:0] b, jsu_pkg::kind_t k, jsu_pkg::err_t code,
                                     logic [15:0] len);
    if (n_step < 4) begin
      step_res[n_step] = '{b, k, code, len, 1'b0};
      n_step++;
    end
  endfunction

  // decoded byte, counted with saturation
  function automatic void add_byte(logic [7:0] b);
    if (str_len != 16'hFFFF) str_len++;
    add_result(b, jsu_pkg::K_BYTE, jsu_pkg::E_NONE, 16'h0000);
  endfunction

  function automatic void clear_work();
    mode = jsu_pkg::M_IDLE;
    hex_cnt = '0;
    acc = '0;
    hi_bits = '0;
    cont_left = '0;
    sb_class = jsu_pkg::C_FULL;
  endfunction

  function automatic void fail_with(jsu_pkg::err_t code);
    clear_work();
    add_result(8'h00, jsu_pkg::K_ERR, code, 16'h0000);
  endfunction

  function automatic void encode_cp(logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  // all results caused by one accepted byte, appended to the output stream
  function automatic void unescape_byte(logic [7:0] c);
    logic [7:0]    esc;
    logic [3:0]    nib;
    logic          is_hex;
    logic [15:0]   cp16;
    logic [7:0]    lo;
    logic [7:0]    hi;
    logic [1:0]    k;
    jsu_pkg::cls_t cls;
    logic          bad;
    n_step = 0;
    case (mode)
      jsu_pkg::M_STR: begin
        if (c == QUOTE) begin
          add_result(8'h00, jsu_pkg::K_END, jsu_pkg::E_NONE, str_len);
          clear_work();
        end else if (c == BSLASH) begin
          mode = jsu_pkg::M_ESC;
        end else if (c < 8'h20) begin
          fail_with(jsu_pkg::E_CTRL);
        end else if (c < 8'h80) begin
          add_byte(c);
        end else begin
          // utf-8 leader and the range class of its second byte
          bad = 1'b0;
          k = 2'd3;
          cls = jsu_pkg::C_FULL;
          if (c >= 8'hC2 && c <= 8'hDF) k = 2'd1;
          else if (c == 8'hE0) begin k = 2'd2; cls = jsu_pkg::C_E0; end
          else if (c == 8'hED) begin k = 2'd2; cls = jsu_pkg::C_ED; end
          else if (c >= 8'hE1 && c <= 8'hEF) k = 2'd2;
          else if (c == 8'hF0) cls = jsu_pkg::C_F0;
          else if (c == 8'hF4) cls = jsu_pkg::C_F4;
          else if (!(c >= 8'hF1 && c <= 8'hF3)) bad = 1'b1;
          if (bad) begin
            fail_with(jsu_pkg::E_BAD_UTF8);
          end else begin
            add_byte(c);
            cont_left = k;
            sb_class = cls;
            mode = jsu_pkg::M_UTF;
          end
        end
      end
      jsu_pkg::M_ESC: begin
        case (c)
          8'h22: esc = 8'h22;
          8'h5C: esc = 8'h5C;
          8'h2F: esc = 8'h2F;
          8'h62: esc = 8'h08;
          8'h66: esc = 8'h0C;
          8'h6E: esc = 8'h0A;
          8'h72: esc = 8'h0D;
          8'h74: esc = 8'h09;
          default: esc = 8'h00;
        endcase
        if (esc != 8'h00) begin
          add_byte(esc);
          mode = jsu_pkg::M_STR;
        end else if (c == LETTER_U) begin
          hex_cnt = '0;
          acc = '0;
          mode = jsu_pkg::M_HEX1;
        end else begin
          fail_with(jsu_pkg::E_BAD_ESC);
        end
      end
      jsu_pkg::M_HEX1, jsu_pkg::M_HEX2: begin
        is_hex = 1'b1;
        nib = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) nib = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) nib = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) nib = 4'(c - 8'h37);
        else is_hex = 1'b0;
        if (!is_hex) begin
          fail_with(jsu_pkg::E_BAD_HEX);
        end else begin
          acc = {acc[11:0], nib};
          if (hex_cnt < 2'd3) begin
            hex_cnt++;
          end else begin
            hex_cnt = '0;
            cp16 = acc;
            acc = '0;
            if (mode == jsu_pkg::M_HEX1) begin
              if (cp16 >= 16'hD800 && cp16 <= 16'hDBFF) begin
                hi_bits = cp16[9:0];
                mode = jsu_pkg::M_SUR_BS;
              end else if (cp16 >= 16'hDC00 && cp16 <= 16'hDFFF) begin
                fail_with(jsu_pkg::E_BAD_SUR);
              end else begin
                mode = jsu_pkg::M_STR;
                encode_cp({5'b0, cp16});
              end
            end else if (cp16 < 16'hDC00 || cp16 > 16'hDFFF) begin
              fail_with(jsu_pkg::E_BAD_SUR);
            end else begin
              encode_cp({1'b0, hi_bits, cp16[9:0]} + 21'h10000);
              hi_bits = '0;
              mode = jsu_pkg::M_STR;
            end
          end
        end
      end
      jsu_pkg::M_SUR_BS: begin
        if (c == BSLASH) mode = jsu_pkg::M_SUR_U;
        else fail_with(jsu_pkg::E_BAD_SUR);
      end
      jsu_pkg::M_SUR_U: begin
        if (c == LETTER_U) begin
          hex_cnt = '0;
          acc = '0;
          mode = jsu_pkg::M_HEX2;
        end else begin
          fail_with(jsu_pkg::E_BAD_SUR);
        end
      end
      jsu_pkg::M_UTF: begin
        lo = 8'h80;
        hi = 8'hBF;
        case (sb_class)
          jsu_pkg::C_E0: lo = 8'hA0;
          jsu_pkg::C_ED: hi = 8'h9F;
          jsu_pkg::C_F0: lo = 8'h90;
          jsu_pkg::C_F4: hi = 8'h8F;
          default: ;
        endcase
        if (c < lo || c > hi) begin
          fail_with(jsu_pkg::E_BAD_UTF8);
        end else begin
          add_byte(c);
          sb_class = jsu_pkg::C_FULL;
          cont_left--;
          if (cont_left == 2'd0) mode = jsu_pkg::M_STR;
        end
      end
      default: begin
        if (c == QUOTE) begin
          clear_work();
          mode = jsu_pkg::M_STR;
          str_len = '0;
        end else begin
          fail_with(jsu_pkg::E_NO_QUOTE);
        end
      end
    endcase
    if (n_step > 0) step_res[n_step - 1].fin = 1'b1;
    for (int i = 0; i < n_step; i++) unescaped_q.push_back(step_res[i]);
  endfunction

  // -------------------------------------------------------------- stimulus

  function automatic void feed(logic [7:0] b);
    raw_bytes_q.push_back('{b, fill_brisk});
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    b = 8'($urandom_range(8'h20, 8'h7F));
    if (b == QUOTE || b == BSLASH) b++;
    return b;
  endfunction

  // \u escape with digits in random case
  function automatic void feed_u(logic [15:0] v);
    logic [3:0] nib;
    feed(BSLASH);
    feed(LETTER_U);
    for (int i = 3; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 4'd10) feed(8'h30 + nib);
      else feed(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10);
    end
  endfunction

  function automatic void feed_bad_hex();
    logic [7:0] b;
    repeat ($urandom_range(0, 3)) feed(8'h30 + 8'($urandom_range(0, 9)));
    do b = 8'($urandom_range(0, 255));
    while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    feed(b);
  endfunction

  // raw utf-8 sequence, optionally with one continuation byte out of range
  function automatic void feed_utf8(logic spoil);
    int         n;
    int         bad_k;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    n = $urandom_range(2, 4);
    case (n)
      2: lead = 8'($urandom_range(8'hC2, 8'hDF));
      3: lead = 8'($urandom_range(8'hE0, 8'hEF));
      default: lead = 8'($urandom_range(8'hF0, 8'hF4));
    endcase
    feed(lead);
    bad_k = spoil ? $urandom_range(1, n - 1) : 0;
    for (int k = 1; k < n; k++) begin
      lo = 8'h80;
      hi = 8'hBF;
      if (k == 1) begin
        if (lead == 8'hE0) lo = 8'hA0;
        if (lead == 8'hED) hi = 8'h9F;
        if (lead == 8'hF0) lo = 8'h90;
        if (lead == 8'hF4) hi = 8'h8F;
      end
      if (k == bad_k) begin
        if ($urandom_range(0, 1)) feed(8'($urandom_range(0, lo - 1)));
        else feed(8'($urandom_range(hi + 1, 255)));
        break;
      end
      feed(8'($urandom_range(lo, hi)));
    end
  endfunction

  // one quoted string of random tokens, sometimes preceded by stray bytes
  // and sometimes cut short by a fault
  function automatic void queue_random_string();
    int         n_tok;
    int         r;
    logic [7:0] b;
    logic [15:0] v;
    logic       broken;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom_range(0, 255));
        if (b == QUOTE) b = ~b;
        feed(b);
      end
    end
    feed(QUOTE);
    broken = 1'b0;
    n_tok = $urandom_range(0, 10);
    for (int t = 0; t < n_tok && !broken; t++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        feed(plain_char());
      end else if (r < 55) begin
        feed(BSLASH);
        feed(esc_letters[$urandom_range(0, 7)]);
      end else if (r < 65) begin
        case ($urandom_range(0, 2))
          0: v = 16'($urandom_range(16'h0000, 16'h007F));
          1: v = 16'($urandom_range(16'h0080, 16'h07FF));
          default: v = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
        feed_u(v);
      end else if (r < 73) begin
        feed_u(16'($urandom_range(16'hD800, 16'hDBFF)));
        feed_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else if (r < 92) begin
        feed_utf8(1'b0);
      end else begin
        broken = 1'b1;
        case ($urandom_range(0, 9))
          0: feed(8'($urandom_range(8'h00, 8'h1F)));
          1: begin
            feed(BSLASH);
            do b = 8'($urandom_range(0, 255));
            while (b inside {8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h75});
            feed(b);
          end
          2: begin
            feed(BSLASH);
            feed(LETTER_U);
            feed_bad_hex();
          end
          3: feed_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
          4: begin
            feed_u(16'($urandom_range(16'hD800, 16'hDBFF)));
            do b = 8'($urandom_range(0, 255));
            while (b == BSLASH);
            feed(b);
          end
          5: begin
            feed_u(16'($urandom_range(16'hD800, 16'hDBFF)));
            feed(BSLASH);
            do b = 8'($urandom_range(0, 255));
            while (b == LETTER_U);
            feed(b);
          end
          6: begin
            feed_u(16'($urandom_range(16'hD800, 16'hDBFF)));
            v = 16'($urandom_range(0, 16'hFFFF));
            if (v >= 16'hDC00 && v <= 16'hDFFF) v = v ^ 16'h2000;
            feed_u(v);
          end
          7: begin
            feed_u(16'($urandom_range(16'hD800, 16'hDBFF)));
            feed(BSLASH);
            feed(LETTER_U);
            feed_bad_hex();
          end
          8: feed($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                       : 8'($urandom_range(8'hF5, 8'hFF)));
          default: feed_utf8(1'b1);
        endcase
      end
    end
    if (!broken) feed(QUOTE);
  endfunction

  // idle length: mostly none or short, a few long, with calm stretches
  function automatic int pick_idle(input logic brisk, inout int calm);
    int r;
    if (brisk) return ($urandom_range(0, 9) == 0) ? 1 : 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // ---------------------------------------------------------------- driver

  // one byte transfer per accepted push, then an optional gap
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        unescape_byte(data_byte);
        sent = raw_bytes_q.pop_front();
        brisk_mode <= sent.brisk;
        n_accepted <= n_accepted + 1;
        gap_left = pick_idle(sent.brisk, tx_calm);
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          push <= 1'b0;
          gap_left--;
        end else if (raw_bytes_q.size() != 0) begin
          push <= 1'b1;
          data_byte <= raw_bytes_q[0].b;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------ long hold

  // the receiver stops once for a long stretch so that the block backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= 40) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // --------------------------------------------------------------- monitor

  // check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (unescaped_q.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing predicted", n_seen));
        end else begin
          want = unescaped_q.pop_front();
          if (out_byte !== want.b)
            flag_error($sformatf("result %0d out_byte %02h, expected %02h",
                                 n_seen, out_byte, want.b));
          if (kind !== want.k)
            flag_error($sformatf("result %0d kind %0d, expected %0d", n_seen, kind, want.k));
          if (error_code !== want.code)
            flag_error($sformatf("result %0d error_code %0d, expected %0d",
                                 n_seen, error_code, want.code));
          if (decoded_length !== want.len)
            flag_error($sformatf("result %0d decoded_length %0d, expected %0d",
                                 n_seen, decoded_length, want.len));
          if (last !== want.fin)
            flag_error($sformatf("result %0d last %0b, expected %0b", n_seen, last, want.fin));
        end
        n_seen++;
        stall_left = pick_idle(brisk_mode, rx_calm);
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_n);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------- stimulus and end

  initial begin
    int base;
    foreach (opening_bytes[i]) feed(opening_bytes[i]);
    // one string of plain bytes offered nearly back to back
    fill_brisk = 1'b1;
    feed(QUOTE);
    repeat (BRISK_STRING_BYTES) feed(plain_char());
    feed(QUOTE);
    fill_brisk = 1'b0;
    base = raw_bytes_q.size();
    while (raw_bytes_q.size() - base < RANDOM_BYTES) queue_random_string();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for every byte to be taken and every result to be checked
    @(negedge clk);
    while (raw_bytes_q.size() != 0 || push) @(negedge clk);
    while (unescaped_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_check_top.sv
verif/json_string_unescape_utf8_check_top_test.sv
